// File: rtl/pmru_pkg.sv
package pmru_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam logic [2:0] REQ_ADD    = 3'd0;
  localparam logic [2:0] REQ_SELECT = 3'd1;
  localparam logic [2:0] REQ_PIN    = 3'd2;
  localparam logic [2:0] REQ_DELETE = 3'd3;
  localparam logic [2:0] REQ_CLEAR  = 3'd4;

  localparam logic [2:0] STS_ADDED    = 3'd0;
  localparam logic [2:0] STS_DEDUP    = 3'd1;
  localparam logic [2:0] STS_DEGRADED = 3'd2;
  localparam logic [2:0] STS_IGNORED  = 3'd3;
  localparam logic [2:0] STS_TOO_BIG  = 3'd4;
  localparam logic [2:0] STS_PIN_FULL = 3'd5;
  localparam logic [2:0] STS_NOT_FND  = 3'd6;
  localparam logic [2:0] STS_OK       = 3'd7;

  localparam logic [1:0] CFG_HIST_EN = 2'd0;
  localparam logic [1:0] CFG_LIMIT   = 2'd1;
  localparam logic [1:0] CFG_BUDGET  = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] content_key;
    logic [31:0] content_bytes;
    logic        was_trimmed;
    logic [31:0] target_id;
    logic        pin_value;
    logic        clear_pinned_too;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_id;
    logic [4:0]  removed_count;
    logic [4:0]  entry_count;
    logic [31:0] bytes_held;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_KEY,
    S_SCAN_ID,
    S_MOVE,
    S_SET_PIN,
    S_DELETE,
    S_EVICT,
    S_PURGE,
    S_INSERT,
    S_CLEAR,
    S_FINISH
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN,
    OP_TOP,
    OP_EVICT,
    OP_PURGE,
    OP_MOVE,
    OP_PIN,
    OP_DELETE,
    OP_INSERT,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [2:0] code;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       hist_en;
    logic       trimmed;
    logic       at_end;
    logic       hit;
    logic       idx_zero;
    logic       need_room;
    logic       too_large;
    logic       out_free;
  } dp_stat_t;

endpackage

// File: rtl/pmru_ctrl.sv
module pmru_ctrl import pmru_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e     state_q, state_d;
  logic [2:0] code_q, code_d;
  logic       accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= STS_IGNORED;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_DISPATCH;
      S_DISPATCH: begin
        case (stat_i.req_type)
          REQ_ADD: state_d = stat_i.hist_en ? S_SCAN_KEY : S_FINISH;
          REQ_SELECT, REQ_PIN, REQ_DELETE: state_d = S_SCAN_ID;
          REQ_CLEAR: state_d = S_CLEAR;
          default: state_d = S_FINISH;
        endcase
      end
      S_SCAN_KEY: begin
        if (stat_i.at_end) begin
          state_d = stat_i.too_large ? S_FINISH : S_EVICT;
        end else if (stat_i.hit) begin
          state_d = S_MOVE;
        end
      end
      S_SCAN_ID: begin
        if (stat_i.at_end) begin
          state_d = S_FINISH;
        end else if (stat_i.hit) begin
          case (stat_i.req_type)
            REQ_SELECT: state_d = S_MOVE;
            REQ_PIN:    state_d = S_SET_PIN;
            default:    state_d = S_DELETE;
          endcase
        end
      end
      S_MOVE, S_SET_PIN, S_DELETE, S_INSERT: state_d = S_FINISH;
      S_EVICT: begin
        if (stat_i.idx_zero || !stat_i.need_room) begin
          state_d = stat_i.need_room ? S_FINISH : S_PURGE;
        end
      end
      S_PURGE: if (stat_i.idx_zero) state_d = S_INSERT;
      S_CLEAR: if (stat_i.idx_zero) state_d = S_FINISH;
      S_FINISH: if (stat_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op   = OP_NONE;
    cmd_o.code = code_q;
    code_d     = code_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) cmd_o.op = OP_LOAD;
      end
      S_DISPATCH: begin
        code_d = STS_IGNORED;
        if (stat_i.req_type == REQ_CLEAR) begin
          cmd_o.op = OP_TOP;
        end
      end
      S_SCAN_KEY: begin
        if (stat_i.at_end) begin
          if (stat_i.too_large) begin
            code_d = STS_TOO_BIG;
          end else begin
            cmd_o.op = OP_TOP;
          end
        end else begin
          cmd_o.op = OP_SCAN;
          if (stat_i.hit) code_d = stat_i.trimmed ? STS_DEGRADED : STS_DEDUP;
        end
      end
      S_SCAN_ID: begin
        if (stat_i.at_end) begin
          code_d = STS_NOT_FND;
        end else begin
          cmd_o.op = OP_SCAN;
          if (stat_i.hit) code_d = STS_OK;
        end
      end
      S_MOVE:    cmd_o.op = OP_MOVE;
      S_SET_PIN: cmd_o.op = OP_PIN;
      S_DELETE:  cmd_o.op = OP_DELETE;
      S_EVICT: begin
        if (stat_i.idx_zero || !stat_i.need_room) begin
          if (stat_i.need_room) begin
            code_d = STS_PIN_FULL;
          end else begin
            cmd_o.op = OP_TOP;
          end
        end else begin
          cmd_o.op = OP_EVICT;
        end
      end
      S_PURGE: begin
        if (!stat_i.idx_zero) cmd_o.op = OP_PURGE;
      end
      S_INSERT: begin
        cmd_o.op = OP_INSERT;
        code_d   = stat_i.trimmed ? STS_DEGRADED : STS_ADDED;
      end
      S_CLEAR: begin
        if (stat_i.idx_zero) begin
          code_d = STS_OK;
        end else begin
          cmd_o.op = OP_PURGE;
        end
      end
      S_FINISH: begin
        if (stat_i.out_free) cmd_o.op = OP_EMIT;
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// File: rtl/pmru_dpath.sv
module pmru_dpath import pmru_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  req_t        in_data_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  dp_cmd_t     cmd_i,
  output dp_stat_t    stat_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rsp_t        out_data_o
);

  logic [31:0] id_q   [DEPTH];
  logic [63:0] key_q  [DEPTH];
  logic [31:0] size_q [DEPTH];
  logic        pin_q  [DEPTH];
  logic        victim_q [DEPTH];

  logic [CNT_W-1:0] held_count_q;
  logic [31:0]      held_bytes_q;
  logic [31:0]      id_ctr_q;
  logic             hist_en_q;
  logic [4:0]       limit_q;
  logic [31:0]      budget_q;
  logic             out_valid_q;

  req_t             req_q;
  logic [CNT_W-1:0] idx_q;
  logic [IDX_W-1:0] pos_q;
  logic [CNT_W-1:0] rc_q;
  logic [31:0]      rb_q;
  logic [CNT_W-1:0] removed_q;
  logic [31:0]      rid_q;
  rsp_t             out_q;

  logic [IDX_W-1:0] cur;
  logic [CNT_W-1:0] idx_m1;
  logic [IDX_W-1:0] j;
  logic [31:0]      lim32;
  logic [32:0]      room_sum;
  logic             kill;
  logic [31:0]      next_id;

  assign cur    = idx_q[IDX_W-1:0];
  assign idx_m1 = idx_q - 1'b1;
  assign j      = idx_m1[IDX_W-1:0];
  assign lim32  = ({27'd0, limit_q} > 32'(DEPTH)) ? 32'(DEPTH) : {27'd0, limit_q};
  assign room_sum = {1'b0, rb_q} + {1'b0, req_q.content_bytes};
  assign kill   = (req_q.req_type == REQ_CLEAR) ?
                  (req_q.clear_pinned_too || !pin_q[j]) : victim_q[j];
  assign next_id = (id_ctr_q == 32'hFFFF_FFFF) ? 32'd1 : id_ctr_q + 32'd1;

  always_comb begin
    stat_o.req_type  = req_q.req_type;
    stat_o.hist_en   = hist_en_q;
    stat_o.trimmed   = req_q.was_trimmed;
    stat_o.at_end    = (idx_q == held_count_q);
    stat_o.hit       = (req_q.req_type == REQ_ADD) ?
                       (key_q[cur] == req_q.content_key &&
                        size_q[cur] == req_q.content_bytes) :
                       (id_q[cur] == req_q.target_id);
    stat_o.idx_zero  = (idx_q == '0);
    stat_o.need_room = (32'(rc_q) >= lim32) || (room_sum > {1'b0, budget_q});
    stat_o.too_large = (req_q.content_bytes > budget_q);
    stat_o.out_free  = !out_valid_q || !out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count_q <= '0;
      held_bytes_q <= '0;
      id_ctr_q     <= '0;
      hist_en_q    <= 1'b1;
      limit_q      <= 5'd16;
      budget_q     <= 32'd16777216;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_HIST_EN: hist_en_q <= cfg_data_i[0];
          CFG_LIMIT:   limit_q   <= cfg_data_i[4:0];
          CFG_BUDGET:  budget_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_PURGE: begin
          if (kill) begin
            held_count_q <= held_count_q - 1'b1;
            held_bytes_q <= held_bytes_q - size_q[j];
          end
        end
        OP_DELETE: begin
          held_count_q <= held_count_q - 1'b1;
          held_bytes_q <= held_bytes_q - size_q[pos_q];
        end
        OP_INSERT: begin
          held_count_q <= held_count_q + 1'b1;
          held_bytes_q <= held_bytes_q + req_q.content_bytes;
          id_ctr_q     <= next_id;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        req_q     <= in_data_i;
        idx_q     <= '0;
        rc_q      <= held_count_q;
        rb_q      <= held_bytes_q;
        removed_q <= '0;
        rid_q     <= '0;
        for (int k = 0; k < DEPTH; k++) victim_q[k] <= 1'b0;
      end
      OP_SCAN: begin
        pos_q <= cur;
        if (!stat_o.hit) idx_q <= idx_q + 1'b1;
      end
      OP_TOP: idx_q <= held_count_q;
      OP_EVICT: begin
        idx_q <= idx_m1;
        if (!pin_q[j]) begin
          victim_q[j] <= 1'b1;
          rc_q        <= rc_q - 1'b1;
          rb_q        <= rb_q - size_q[j];
        end
      end
      OP_PURGE: begin
        idx_q <= idx_m1;
        if (kill) begin
          removed_q <= removed_q + 1'b1;
          for (int k = 0; k < DEPTH - 1; k++) begin
            if (k >= int'(j)) begin
              id_q[k]   <= id_q[k+1];
              key_q[k]  <= key_q[k+1];
              size_q[k] <= size_q[k+1];
              pin_q[k]  <= pin_q[k+1];
            end
          end
        end
      end
      OP_MOVE: begin
        rid_q     <= id_q[pos_q];
        id_q[0]   <= id_q[pos_q];
        key_q[0]  <= key_q[pos_q];
        size_q[0] <= size_q[pos_q];
        pin_q[0]  <= pin_q[pos_q];
        for (int k = 1; k < DEPTH; k++) begin
          if (k <= int'(pos_q)) begin
            id_q[k]   <= id_q[k-1];
            key_q[k]  <= key_q[k-1];
            size_q[k] <= size_q[k-1];
            pin_q[k]  <= pin_q[k-1];
          end
        end
      end
      OP_PIN: pin_q[pos_q] <= req_q.pin_value;
      OP_DELETE: begin
        removed_q <= CNT_W'(1);
        for (int k = 0; k < DEPTH - 1; k++) begin
          if (k >= int'(pos_q)) begin
            id_q[k]   <= id_q[k+1];
            key_q[k]  <= key_q[k+1];
            size_q[k] <= size_q[k+1];
            pin_q[k]  <= pin_q[k+1];
          end
        end
      end
      OP_INSERT: begin
        rid_q     <= next_id;
        id_q[0]   <= next_id;
        key_q[0]  <= req_q.content_key;
        size_q[0] <= req_q.content_bytes;
        pin_q[0]  <= 1'b0;
        for (int k = 1; k < DEPTH; k++) begin
          id_q[k]   <= id_q[k-1];
          key_q[k]  <= key_q[k-1];
          size_q[k] <= size_q[k-1];
          pin_q[k]  <= pin_q[k-1];
        end
      end
      OP_EMIT: begin
        out_q.status        <= cmd_i.code;
        out_q.result_id     <= rid_q;
        out_q.removed_count <= 5'(removed_q);
        out_q.entry_count   <= 5'(held_count_q);
        out_q.bytes_held    <= held_bytes_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/pinned_mru_table_byte_budget.sv
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_stall_o  in_data_i  (req_t)
// out       output     out_valid_o / out_stall_i out_data_o (rsp_t)
// cfg       input      cfg_we_i                 cfg_index_i, cfg_data_i
//
// One request at a time; the scan, eviction and compaction passes each
// take one entry per cycle. An add with history on and no match runs
// search, victim scan, compaction and insert unless too big or pin-full.
// Reset empties the table and loads the register defaults; no clearing pass.
// A stalled result holds in the output register while the next request runs.
module pinned_mru_table_byte_budget import pmru_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rsp_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pmru_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pmru_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: sim/pinned_mru_table_byte_budget_test.sv
`timescale 1ns / 1ps

module pinned_mru_table_byte_budget_test;
  import pmru_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  req_t        in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  rsp_t        out_data_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  pinned_mru_table_byte_budget dut (.*);

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // table mirror
  logic [31:0] tbl_id [DEPTH];
  logic [63:0] tbl_key [DEPTH];
  logic [31:0] tbl_size [DEPTH];
  logic        tbl_pin [DEPTH];
  int unsigned tbl_count;
  logic [31:0] tbl_bytes;
  logic [31:0] last_id;
  logic        hist_en;
  logic [4:0]  lim_reg;
  logic [31:0] budget;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   error_count;
  int   send_idle_pct;
  int   recv_stall_pct;
  longint cycle_count;

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  task automatic tbl_copy(input int d, input int s);
    tbl_id[d] = tbl_id[s];
    tbl_key[d] = tbl_key[s];
    tbl_size[d] = tbl_size[s];
    tbl_pin[d] = tbl_pin[s];
  endtask

  task automatic tbl_to_front(input int p);
    logic [31:0] i0;
    logic [63:0] k0;
    logic [31:0] s0;
    logic        p0;
    i0 = tbl_id[p]; k0 = tbl_key[p]; s0 = tbl_size[p]; p0 = tbl_pin[p];
    for (int k = p; k > 0; k--) tbl_copy(k, k - 1);
    tbl_id[0] = i0; tbl_key[0] = k0; tbl_size[0] = s0; tbl_pin[0] = p0;
  endtask

  function automatic int locate_id(input logic [31:0] id);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_id[i] == id) return i;
    return -1;
  endfunction

  task automatic apply_request(input req_t rq, output rsp_t rs);
    logic [2:0]  st;
    logic [31:0] rid;
    int          removed;
    int          pos;
    int          hit;
    int          lim;
    int          rc;
    int          w;
    logic [32:0] rb;
    logic [31:0] sum;
    logic        victim [DEPTH];
    st = STS_IGNORED;
    rid = '0;
    removed = 0;
    case (rq.req_type)
      REQ_ADD: begin
        if (hist_en) begin
          hit = -1;
          for (int i = 0; i < tbl_count; i++)
            if (hit < 0 && tbl_key[i] == rq.content_key &&
                tbl_size[i] == rq.content_bytes) hit = i;
          if (hit >= 0) begin
            tbl_to_front(hit);
            rid = tbl_id[0];
            st = rq.was_trimmed ? STS_DEGRADED : STS_DEDUP;
          end else if (rq.content_bytes > budget) begin
            st = STS_TOO_BIG;
          end else begin
            lim = (lim_reg > DEPTH) ? DEPTH : lim_reg;
            rc = tbl_count;
            rb = {1'b0, tbl_bytes};
            for (int i = 0; i < DEPTH; i++) victim[i] = 1'b0;
            for (int i = tbl_count; i > 0 &&
                 (rc >= lim || rb + rq.content_bytes > {1'b0, budget}); i--) begin
              if (!tbl_pin[i - 1]) begin
                victim[i - 1] = 1'b1;
                rc--;
                rb -= tbl_size[i - 1];
              end
            end
            if (rc >= lim || rb + rq.content_bytes > {1'b0, budget}) begin
              st = STS_PIN_FULL;
            end else begin
              w = 0;
              for (int r = 0; r < tbl_count; r++) begin
                if (victim[r]) removed++;
                else begin
                  if (w != r) tbl_copy(w, r);
                  w++;
                end
              end
              for (int i = w; i > 0; i--) tbl_copy(i, i - 1);
              last_id = last_id + 1;
              if (last_id == 0) last_id = 1;
              tbl_id[0] = last_id;
              tbl_key[0] = rq.content_key;
              tbl_size[0] = rq.content_bytes;
              tbl_pin[0] = 1'b0;
              tbl_count = w + 1;
              tbl_bytes = rb[31:0] + rq.content_bytes;
              rid = last_id;
              st = rq.was_trimmed ? STS_DEGRADED : STS_ADDED;
            end
          end
        end
      end
      REQ_SELECT, REQ_PIN, REQ_DELETE: begin
        pos = locate_id(rq.target_id);
        if (pos < 0) st = STS_NOT_FND;
        else begin
          st = STS_OK;
          if (rq.req_type == REQ_SELECT) begin
            tbl_to_front(pos);
            rid = tbl_id[0];
          end else if (rq.req_type == REQ_PIN) begin
            tbl_pin[pos] = rq.pin_value;
          end else begin
            tbl_bytes -= tbl_size[pos];
            for (int k = pos; k + 1 < tbl_count; k++) tbl_copy(k, k + 1);
            tbl_count--;
            removed = 1;
          end
        end
      end
      REQ_CLEAR: begin
        w = 0;
        sum = '0;
        for (int r = 0; r < tbl_count; r++) begin
          if (rq.clear_pinned_too || !tbl_pin[r]) removed++;
          else begin
            if (w != r) tbl_copy(w, r);
            sum += tbl_size[r];
            w++;
          end
        end
        tbl_count = w;
        tbl_bytes = sum;
        st = STS_OK;
      end
      default: ;
    endcase
    rs.status = st;
    rs.result_id = rid;
    rs.removed_count = removed[4:0];
    rs.entry_count = tbl_count[4:0];
    rs.bytes_held = tbl_bytes;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t rs;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      if (in_valid_i && !in_stall_o) begin
        apply_request(in_data_i, rs);
        expected_rsps.push_back(rs);
        void'(pending_reqs.pop_front());
      end
      if (in_valid_i && in_stall_o) begin
        in_valid_i <= 1'b1;
      end else if (pending_reqs.size() > 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_reqs[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    rsp_t ex;
    cycle_count <= cycle_count + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rsps.size() == 0) begin
        report("result with none expected");
      end else begin
        ex = expected_rsps.pop_front();
        if (out_data_o.status != ex.status)
          report($sformatf("status %0d exp %0d", out_data_o.status, ex.status));
        if (out_data_o.result_id != ex.result_id)
          report($sformatf("result_id %0h exp %0h", out_data_o.result_id,
                           ex.result_id));
        if (out_data_o.removed_count != ex.removed_count)
          report($sformatf("removed_count %0d exp %0d",
                           out_data_o.removed_count, ex.removed_count));
        if (out_data_o.entry_count != ex.entry_count)
          report($sformatf("entry_count %0d exp %0d", out_data_o.entry_count,
                           ex.entry_count));
        if (out_data_o.bytes_held != ex.bytes_held)
          report($sformatf("bytes_held %0h exp %0h", out_data_o.bytes_held,
                           ex.bytes_held));
      end
    end
    if (cycle_count > 2000000) begin
      $display("pinned_mru_table_byte_budget_test: errors");
      $finish;
    end
  end

  function automatic req_t blank_req(input logic [2:0] op);
    req_t r;
    r = '0;
    r.req_type = op;
    return r;
  endfunction

  function automatic logic [31:0] some_id();
    if (tbl_count > 0 && $urandom_range(9) < 8)
      return tbl_id[$urandom_range(tbl_count - 1)];
    if ($urandom_range(1)) return last_id + $urandom_range(3);
    return $urandom();
  endfunction

  // queued-state ids are approximate; predictor resolves the truth
  function automatic req_t random_req(input logic [31:0] max_size);
    req_t r;
    int   pick;
    r = '0;
    r.content_key = {$urandom(), $urandom()};
    if ($urandom_range(3) != 0) r.content_key = {60'h0, 4'($urandom_range(11))};
    r.content_bytes = $urandom_range(max_size);
    if ($urandom_range(7) == 0) r.content_bytes = $urandom();
    if ($urandom_range(2) != 0) r.content_bytes = {28'h0, r.content_key[3:0]} * 37;
    r.was_trimmed = 1'($urandom_range(1));
    r.pin_value = 1'($urandom_range(1));
    r.clear_pinned_too = 1'($urandom_range(1));
    r.target_id = some_id();
    if ($urandom_range(15) == 0) r.target_id = $urandom();
    pick = $urandom_range(99);
    if (pick < 50) r.req_type = REQ_ADD;
    else if (pick < 62) r.req_type = REQ_SELECT;
    else if (pick < 80) r.req_type = REQ_PIN;
    else if (pick < 92) r.req_type = REQ_DELETE;
    else if (pick < 97) r.req_type = REQ_CLEAR;
    else r.req_type = 3'($urandom_range(7));
    return r;
  endfunction

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_HIST_EN: hist_en = val[0];
      CFG_LIMIT:   lim_reg = val[4:0];
      default:     budget = val;
    endcase
  endtask

  initial begin
    req_t r;
    int   lims [6];
    logic [31:0] buds [6];
    lims = '{16, 1, 31, 0, 4, 9};
    buds = '{32'hFFFF_FFFF, 32'd0, 32'd400, 32'd1000, 32'd16777216, 32'd250};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_HIST_EN;
    cfg_data_i = '0;
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    tbl_count = 0;
    tbl_bytes = '0;
    last_id = '0;
    hist_en = 1'b1;
    lim_reg = 5'd16;
    budget = 32'd16777216;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed
    r = blank_req(REQ_SELECT); r.target_id = 32'd0; pending_reqs.push_back(r);
    r = blank_req(REQ_ADD); r.content_key = '1; r.content_bytes = 32'd16777216;
    pending_reqs.push_back(r);
    r = blank_req(REQ_ADD); r.content_key = '0; r.content_bytes = 32'd16777217;
    pending_reqs.push_back(r);
    r = blank_req(REQ_ADD); r.content_key = '0; r.content_bytes = 32'd0;
    r.was_trimmed = 1'b1; pending_reqs.push_back(r);
    r = blank_req(REQ_ADD); r.content_key = '1; r.content_bytes = 32'd16777216;
    pending_reqs.push_back(r);
    r = blank_req(REQ_ADD); r.content_key = '1; r.content_bytes = 32'd16777216;
    r.was_trimmed = 1'b1; pending_reqs.push_back(r);
    r = blank_req(REQ_PIN); r.target_id = 32'd1; r.pin_value = 1'b1;
    pending_reqs.push_back(r);
    r = blank_req(REQ_ADD); r.content_key = 64'h5; r.content_bytes = 32'd1;
    pending_reqs.push_back(r);
    r = blank_req(REQ_SELECT); r.target_id = 32'd2; pending_reqs.push_back(r);
    r = blank_req(REQ_DELETE); r.target_id = 32'd2; pending_reqs.push_back(r);
    r = blank_req(REQ_DELETE); r.target_id = 32'hFFFF_FFFF; pending_reqs.push_back(r);
    r = blank_req(3'd5); pending_reqs.push_back(r);
    r = blank_req(3'd7); r = '1; pending_reqs.push_back(r);
    r = blank_req(REQ_CLEAR); pending_reqs.push_back(r);
    r = blank_req(REQ_PIN); r.target_id = 32'd1; pending_reqs.push_back(r);
    r = blank_req(REQ_CLEAR); r.clear_pinned_too = 1'b1; pending_reqs.push_back(r);
    drain();

    write_reg(CFG_HIST_EN, 32'd0);
    r = blank_req(REQ_ADD); r.content_key = 64'h9; pending_reqs.push_back(r);
    r = blank_req(REQ_CLEAR); r.clear_pinned_too = 1'b1; pending_reqs.push_back(r);
    drain();
    write_reg(CFG_HIST_EN, 32'd1);

    // random phases
    for (int ph = 0; ph < 24; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      write_reg(CFG_LIMIT, 32'(lims[ph % 6]));
      write_reg(CFG_BUDGET, buds[(ph / 2) % 6]);
      if (ph == 23) write_reg(CFG_HIST_EN, 32'd0);
      for (int n = 0; n < 46; n++)
        pending_reqs.push_back(random_req(ph % 3 == 0 ? 32'd150 : 32'd60));
      if (ph % 5 == 4) begin
        r = blank_req(REQ_CLEAR); r.clear_pinned_too = 1'b1;
        pending_reqs.push_back(r);
      end
      drain();
      if (ph == 23) write_reg(CFG_HIST_EN, 32'd1);
    end

    if (error_count == 0) begin
      $display("pinned_mru_table_byte_budget_test: clean");
    end else begin
      $display("pinned_mru_table_byte_budget_test: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/pmru_pkg.sv
rtl/pmru_ctrl.sv
rtl/pmru_dpath.sv
rtl/pinned_mru_table_byte_budget.sv
sim/pinned_mru_table_byte_budget_test.sv
